// ===== rtl/core/cpts_pkg.sv =====
// Package for the counter/priority task scheduler.
// Holds sizes, op codes, beat and slot-row types, and the FSM state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpts_pkg;

  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SLICE_W   = 9;
  localparam int PRIO_W    = 8;
  localparam int DEPTH_W   = 8;

  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_YIELD      = 3'd1;
  localparam logic [2:0] OP_CREATE     = 3'd2;
  localparam logic [2:0] OP_SET_RUN    = 3'd3;
  localparam logic [2:0] OP_PREEMPT_DI = 3'd4;
  localparam logic [2:0] OP_PREEMPT_EN = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] slot;
    logic [7:0] priority_req;
    logic       running;
  } in_t;

  typedef struct packed {
    logic [5:0] current_task;
    logic       switched;
    logic [8:0] current_counter;
  } out_t;

  typedef struct packed {
    logic [SLICE_W-1:0] slice;
    logic [PRIO_W-1:0]  prio;
    logic [DEPTH_W-1:0] depth;
  } row_t;

  localparam row_t ROW0_RESET = '{slice: '0, prio: PRIO_W'(1), depth: '0};

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MOD,
    S_SCAN,
    S_CHG,
    S_FIN,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/cpts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/counter_priority_task_scheduler.sv =====
// Counter/priority task scheduler, top level.
// Depends on cpts_pkg and cpts_ram (slice/priority/depth table).
// Create, set-state and unused ops pass through the load, finish and output states;
// tick, yield and preempt ops add a modify state between load and finish.
// Rescheduling scans the table one slot per cycle through the single RAM
// read port; when the best runnable slot's slice is zero, a recharge pass and a second scan follow.
// One item at a time; in_ready is high only while idle, in the cycle after the result loads.
// Reset (sync, rst_n low): control, valid and running bits clear to slot 0 only;
// slot 0's row reads as its reset value until first written. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module counter_priority_task_scheduler (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cpts_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cpts_pkg::out_t     out_data
);

  import cpts_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_TASKS - 1);

  state_t state_r, state_nxt;

  logic [2:0]           op_r, op_nxt;
  logic [5:0]           slot_r, slot_nxt;
  logic [PRIO_W-1:0]    prio_r, prio_nxt;
  logic                 run_in_r, run_in_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic [MAX_TASKS-1:0] runb_r, runb_nxt;
  logic                 s0_wr_r, s0_wr_nxt;
  logic                 sub_r, sub_nxt;
  logic [IDX_W-1:0]     scan_rd_r, scan_rd_nxt;
  logic                 issue_end_r, issue_end_nxt;
  logic                 dat_vld_r, dat_vld_nxt;
  logic [IDX_W-1:0]     dat_idx_r, dat_idx_nxt;
  logic [SLICE_W-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic                 found_r, found_nxt;
  logic                 chg_done_r, chg_done_nxt;
  logic                 sw_r, sw_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  row_t             wr_data;
  logic [IDX_W-1:0] rd_addr;
  row_t             ram_q;
  row_t             row;

  logic               in_acc;
  logic               slot_ok;
  logic [IDX_W-1:0]   slot_idx;
  logic [PRIO_W-1:0]  prio_eff;
  logic [SLICE_W-1:0] tick_slice;
  logic               mod_resched;
  logic               cand;
  logic               better;
  logic [SLICE_W-1:0] best_n;
  logic [IDX_W-1:0]   pick_n;
  logic               found_n;
  logic               pass_end;
  logic               start_pass;
  logic [SLICE_W:0]   chg_sum;
  logic               out_load;

  cpts_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign in_acc     = in_valid && in_ready;
  assign row        = sub_r ? ROW0_RESET : ram_q;
  assign slot_ok    = (32'(slot_r) < 32'(MAX_TASKS));
  assign slot_idx   = IDX_W'(slot_r);
  assign prio_eff   = (prio_r == '0) ? PRIO_W'(1) : prio_r;
  assign tick_slice = (row.slice != '0) ? row.slice - SLICE_W'(1) : '0;
  assign mod_resched = (op_r == OP_YIELD) ||
                       ((op_r == OP_TICK) && (tick_slice == '0) && (row.depth == '0));

  assign cand     = dat_vld_r && valid_r[dat_idx_r] && runb_r[dat_idx_r];
  assign better   = cand && (!found_r || (row.slice > best_r));
  assign best_n   = better ? row.slice : best_r;
  assign pick_n   = better ? dat_idx_r : pick_r;
  assign found_n  = found_r || cand;
  assign pass_end = dat_vld_r && (dat_idx_r == LAST);
  assign chg_sum  = (SLICE_W + 1)'(row.slice >> 1) + (SLICE_W + 1)'(row.prio);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if ((op_r == OP_TICK) || (op_r == OP_YIELD) ||
            (op_r == OP_PREEMPT_DI) || (op_r == OP_PREEMPT_EN)) begin
          state_nxt = S_MOD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MOD: begin
        state_nxt = mod_resched ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        if (pass_end) begin
          state_nxt = (found_n && (best_n == '0) && !chg_done_r) ? S_CHG : S_FIN;
        end
      end
      S_CHG: begin
        if (pass_end) state_nxt = S_SCAN;
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs: RAM ports and input ready
  always_comb begin
    in_ready = (state_r == S_IDLE);
    rd_addr  = cur_r;
    wr_en    = 1'b0;
    wr_addr  = cur_r;
    wr_data  = row;
    unique case (state_r)
      S_LOAD: begin
        if ((op_r == OP_CREATE) && slot_ok) begin
          wr_en   = 1'b1;
          wr_addr = slot_idx;
          wr_data = '{slice: SLICE_W'(prio_eff), prio: prio_eff, depth: '0};
        end
      end
      S_MOD: begin
        unique case (op_r)
          OP_TICK: begin
            wr_en         = 1'b1;
            wr_data.slice = tick_slice;
          end
          OP_YIELD: begin
            wr_en         = 1'b1;
            wr_data.slice = '0;
          end
          OP_PREEMPT_DI: begin
            wr_en = 1'b1;
            if (row.depth != '1) wr_data.depth = row.depth + DEPTH_W'(1);
          end
          OP_PREEMPT_EN: begin
            wr_en = 1'b1;
            if (row.depth != '0) wr_data.depth = row.depth - DEPTH_W'(1);
          end
          default: wr_en = 1'b0;
        endcase
      end
      S_SCAN: begin
        rd_addr = scan_rd_r;
      end
      S_CHG: begin
        rd_addr = scan_rd_r;
        wr_addr = dat_idx_r;
        if (dat_vld_r && valid_r[dat_idx_r]) begin
          wr_en         = 1'b1;
          wr_data.slice = chg_sum[SLICE_W] ? '1 : chg_sum[SLICE_W-1:0];
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    prio_nxt      = prio_r;
    run_in_nxt    = run_in_r;
    cur_nxt       = cur_r;
    valid_nxt     = valid_r;
    runb_nxt      = runb_r;
    s0_wr_nxt     = s0_wr_r || (wr_en && (wr_addr == '0));
    sub_nxt       = (rd_addr == '0) && !s0_wr_r;
    scan_rd_nxt   = scan_rd_r;
    issue_end_nxt = issue_end_r;
    dat_vld_nxt   = 1'b0;
    dat_idx_nxt   = scan_rd_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    chg_done_nxt  = chg_done_r || (state_r == S_CHG);
    sw_nxt        = sw_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    if (in_acc) begin
      op_nxt       = in_data.op;
      slot_nxt     = in_data.slot;
      prio_nxt     = in_data.priority_req;
      run_in_nxt   = in_data.running;
      sw_nxt       = 1'b0;
      chg_done_nxt = 1'b0;
    end

    if ((state_r == S_LOAD) && slot_ok) begin
      if (op_r == OP_CREATE) begin
        valid_nxt[slot_idx] = 1'b1;
        runb_nxt[slot_idx]  = run_in_r;
      end else if (op_r == OP_SET_RUN) begin
        runb_nxt[slot_idx] = run_in_r;
      end
    end

    if ((state_r == S_SCAN) || (state_r == S_CHG)) begin
      dat_vld_nxt = !issue_end_r;
      if (!issue_end_r) begin
        if (scan_rd_r == LAST) begin
          issue_end_nxt = 1'b1;
        end else begin
          scan_rd_nxt = scan_rd_r + IDX_W'(1);
        end
      end
      if (state_r == S_SCAN) begin
        best_nxt  = best_n;
        pick_nxt  = pick_n;
        found_nxt = found_n;
        if (pass_end && (state_nxt == S_FIN)) begin
          cur_nxt = found_n ? pick_n : '0;
          sw_nxt  = (found_n ? pick_n : '0) != cur_r;
        end
      end
    end

    start_pass = ((state_nxt == S_SCAN) || (state_nxt == S_CHG)) && (state_nxt != state_r);
    if (start_pass) begin
      scan_rd_nxt   = '0;
      issue_end_nxt = 1'b0;
      dat_vld_nxt   = 1'b0;
      best_nxt      = '0;
      pick_nxt      = '0;
      found_nxt     = 1'b0;
    end

    if (out_load) begin
      out_data_nxt.current_task    = 6'(cur_r);
      out_data_nxt.switched        = sw_r;
      out_data_nxt.current_counter = row.slice;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      valid_r     <= MAX_TASKS'(1);
      runb_r      <= MAX_TASKS'(1);
      s0_wr_r     <= 1'b0;
      issue_end_r <= 1'b0;
      dat_vld_r   <= 1'b0;
      chg_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      valid_r     <= valid_nxt;
      runb_r      <= runb_nxt;
      s0_wr_r     <= s0_wr_nxt;
      issue_end_r <= issue_end_nxt;
      dat_vld_r   <= dat_vld_nxt;
      chg_done_r  <= chg_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    slot_r     <= slot_nxt;
    prio_r     <= prio_nxt;
    run_in_r   <= run_in_nxt;
    sub_r      <= sub_nxt;
    scan_rd_r  <= scan_rd_nxt;
    dat_idx_r  <= dat_idx_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    found_r    <= found_nxt;
    sw_r       <= sw_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/cpts_checker.sv =====
// Port-level checker for the task scheduler, bound to the top level.
// Depends on cpts_pkg and counter_priority_task_scheduler.
`timescale 1ns / 1ps
`default_nettype none

module cpts_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire cpts_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire cpts_pkg::out_t out_data
);

  import cpts_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r + 2'(in_beat) - 2'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without an accepted item");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |-> pend_r <= 2'd1)
    else $error("item accepted while another is still in work");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.switched |->
      pend_r != 2'd0 && int'(out_data.current_task) < MAX_TASKS)
    else $error("switch reported to a slot outside the table");

endmodule

bind counter_priority_task_scheduler cpts_checker u_cpts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/counter_priority_task_scheduler_checker.sv =====
// Scoreboard for the counter/priority task scheduler: watches both channels,
// predicts each result beat from its own copy of the slot table and compares.
// Depends on cpts_pkg for beat types, sizes and op codes.
`timescale 1ns / 1ps

module counter_priority_task_scheduler_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  cpts_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  cpts_pkg::out_t out_data,
  output int             mismatches,
  output int             outstanding
);

  import cpts_pkg::*;

  bit                 slot_ok   [MAX_TASKS];
  bit                 slot_run  [MAX_TASKS];
  logic [SLICE_W-1:0] slice_left[MAX_TASKS];
  logic [PRIO_W-1:0]  slot_prio [MAX_TASKS];
  logic [DEPTH_W-1:0] slot_depth[MAX_TASKS];
  logic [IDX_W-1:0]   cur_slot;

  out_t expected_status[$];

  function automatic void clear_table();
    for (int i = 0; i < MAX_TASKS; i++) begin
      slot_ok[i]    = (i == 0);
      slot_run[i]   = (i == 0);
      slice_left[i] = '0;
      slot_prio[i]  = (i == 0) ? PRIO_W'(1) : '0;
      slot_depth[i] = '0;
    end
    cur_slot = '0;
  endfunction

  function automatic void best_candidate(output logic [IDX_W-1:0] pick,
                                         output logic [SLICE_W-1:0] best,
                                         output bit any);
    pick = '0;
    best = '0;
    any  = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (slot_ok[i] && slot_run[i] && (!any || slice_left[i] > best)) begin
        best = slice_left[i];
        pick = IDX_W'(i);
        any  = 1'b1;
      end
    end
  endfunction

  function automatic void recharge_slices();
    int v;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (slot_ok[i]) begin
        v = int'(slice_left[i] >> 1) + int'(slot_prio[i]);
        if (v > 511) v = 511;
        slice_left[i] = SLICE_W'(v);
      end
    end
  endfunction

  function automatic void pick_next_task();
    logic [IDX_W-1:0]   pick;
    logic [SLICE_W-1:0] best;
    bit                 any;
    best_candidate(pick, best, any);
    if (any && best == '0) begin
      recharge_slices();
      best_candidate(pick, best, any);
    end
    cur_slot = any ? pick : '0;
  endfunction

  function automatic out_t advance_scheduler(in_t beat);
    logic [IDX_W-1:0]  prev;
    logic [PRIO_W-1:0] p;
    bit                sw;
    out_t              r;
    prev = cur_slot;
    sw   = 1'b0;
    case (beat.op)
      OP_TICK: begin
        if (slice_left[prev] != '0) slice_left[prev] = slice_left[prev] - SLICE_W'(1);
        if (slice_left[prev] == '0 && slot_depth[prev] == '0) begin
          pick_next_task();
          sw = (cur_slot != prev);
        end
      end
      OP_YIELD: begin
        slice_left[prev] = '0;
        pick_next_task();
        sw = (cur_slot != prev);
      end
      OP_CREATE: begin
        p = (beat.priority_req == '0) ? PRIO_W'(1) : beat.priority_req;
        slot_ok[beat.slot]    = 1'b1;
        slot_run[beat.slot]   = beat.running;
        slot_prio[beat.slot]  = p;
        slice_left[beat.slot] = SLICE_W'(p);
        slot_depth[beat.slot] = '0;
      end
      OP_SET_RUN: slot_run[beat.slot] = beat.running;
      OP_PREEMPT_DI: begin
        if (slot_depth[prev] != '1) slot_depth[prev] = slot_depth[prev] + DEPTH_W'(1);
      end
      OP_PREEMPT_EN: begin
        if (slot_depth[prev] != '0) slot_depth[prev] = slot_depth[prev] - DEPTH_W'(1);
      end
      default: ;
    endcase
    r.current_task    = cur_slot;
    r.switched        = sw;
    r.current_counter = slice_left[cur_slot];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      clear_table();
      expected_status.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, actual task=%0d %s%0d %0d",
                   $time, out_data.current_task, "switched/counter=",
                   out_data.switched, out_data.current_counter);
        end else begin
          want = expected_status.pop_front();
          if (want.current_task !== out_data.current_task ||
              want.switched !== out_data.switched ||
              want.current_counter !== out_data.current_counter) begin
            mismatches++;
            $display("%0t: mismatch expected task=%0d switched=%0d counter=%0d, %s%0d %0d %0d",
                     $time, want.current_task, want.switched, want.current_counter,
                     "actual task/switched/counter=", out_data.current_task,
                     out_data.switched, out_data.current_counter);
          end
        end
      end
      if (in_valid && in_ready)
        expected_status.push_back(advance_scheduler(in_data));
    end
    outstanding = expected_status.size();
  end

endmodule

// ===== tb/sv/counter_priority_task_scheduler_test.sv =====
// Testbench top for the counter/priority task scheduler: clock, reset,
// directed and random op beats with bursty sending and receiver stalls.
// Depends on cpts_pkg, the block and counter_priority_task_scheduler_checker.
`timescale 1ns / 1ps

module counter_priority_task_scheduler_test;
  import cpts_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   mismatches;
  int   outstanding;
  int   burst_left;

  counter_priority_task_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  counter_priority_task_scheduler_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic in_t job(logic [2:0] op, logic [5:0] slot, logic [7:0] pr, logic run);
    in_t b;
    b.op           = op;
    b.slot         = slot;
    b.priority_req = pr;
    b.running      = run;
    return b;
  endfunction

  // Mostly small slot numbers and short slices so ticks exhaust counters often.
  function automatic in_t random_job();
    int         w;
    logic [2:0] op;
    logic [5:0] slot;
    logic [7:0] pr;
    w = $urandom_range(0, 99);
    if (w < 40)      op = OP_TICK;
    else if (w < 50) op = OP_YIELD;
    else if (w < 65) op = OP_CREATE;
    else if (w < 80) op = OP_SET_RUN;
    else if (w < 88) op = OP_PREEMPT_DI;
    else if (w < 96) op = OP_PREEMPT_EN;
    else if (w < 98) op = OP_SPARE_6;
    else             op = OP_SPARE_7;
    slot = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
    w = $urandom_range(0, 9);
    if (w < 6)      pr = 8'($urandom_range(1, 6));
    else if (w < 8) pr = '0;
    else            pr = 8'($urandom_range(0, 255));
    return job(op, slot, pr, $urandom_range(0, 9) < 8);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_job(in_t b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int ph;
    int mode;
    out_ready = 1'b0;
    ph = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 300)) begin
        @(negedge clk);
        ph++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (ph % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    burst_left = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // slot 0 starts with an empty slice: first tick forces a recharge
    send_job(job(OP_TICK, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_SPARE_6, 6'd63, 8'd255, 1'b1));
    send_job(job(OP_SPARE_7, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_CREATE, 6'd63, 8'd255, 1'b1));
    send_job(job(OP_CREATE, 6'd1, 8'd0, 1'b1));
    send_job(job(OP_SET_RUN, 6'd10, 8'd0, 1'b1));
    send_job(job(OP_CREATE, 6'd5, 8'd3, 1'b0));
    send_job(job(OP_YIELD, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_PREEMPT_DI, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_TICK, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_YIELD, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_PREEMPT_EN, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_PREEMPT_EN, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_TICK, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_PREEMPT_DI, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_TICK, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_TICK, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_PREEMPT_EN, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_TICK, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_SET_RUN, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_SET_RUN, 6'd1, 8'd0, 1'b0));
    send_job(job(OP_SET_RUN, 6'd63, 8'd0, 1'b0));
    send_job(job(OP_YIELD, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_SET_RUN, 6'd0, 8'd0, 1'b1));
    send_job(job(OP_SET_RUN, 6'd1, 8'd0, 1'b1));
    drain();

    repeat (320) send_job(random_job());
    drain();

    // preempt depth up to its ceiling, then ticks that must not reschedule
    repeat (258) send_job(job(OP_PREEMPT_DI, 6'($urandom_range(0, 63)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    repeat (3) send_job(job(OP_TICK, 6'd0, 8'd0, 1'b0));
    send_job(job(OP_YIELD, 6'd0, 8'd0, 1'b0));

    repeat (320) send_job(random_job());
    drain();
    repeat (3 * MAX_TASKS + 20) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cpts_pkg.sv
rtl/core/cpts_ram.sv
rtl/core/counter_priority_task_scheduler.sv
rtl/core/cpts_checker.sv
tb/sv/counter_priority_task_scheduler_checker.sv
tb/sv/counter_priority_task_scheduler_test.sv
